// File: rtl/core/polygon_plane_newell_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polygon plane block.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PLANE_NEWELL_DEFINES_SVH
`define POLYGON_PLANE_NEWELL_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define PNN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must be followed by another in the next cycle.
`define PNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pnn_pkg.sv
// ----------------------------------------------------------------------------
// pnn_pkg
// Shared constants, types and state encodings of the polygon plane block.
// ----------------------------------------------------------------------------
`default_nettype none

package pnn_pkg;

  localparam int unsigned MAX_VERTICES_DEF     = 1024;
  localparam int unsigned COORD_BITS_DEF       = 24;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

  localparam int unsigned ACC_W      = 60;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned OFFSET_W   = 25;
  localparam int unsigned NORMAL_W   = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned TOL_W      = 32;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef enum logic [1:0] {
    F_RUN,
    F_CLOSE,
    F_WAIT,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MAG,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DIVN_S,
    B_DIVN_W,
    B_DOT,
    B_DIVD_S,
    B_DIVD_W,
    B_OUT
  } back_state_e;

  // Accumulated loop data handed from the front end to the back end.
  typedef struct packed {
    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic               overflow;
    logic               degenerate;
    logic [COUNT_W-1:0] vertex_count;
    logic [SUM_W-1:0]   sum_z;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_x;
    logic [OFFSET_W-1:0] plane_offset;
    logic [NORMAL_W-1:0] normal_z;
    logic [NORMAL_W-1:0] normal_y;
    logic [NORMAL_W-1:0] normal_x;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/pnn_front.sv
// ----------------------------------------------------------------------------
// pnn_front
// Vertex intake: Newell cross terms, coordinate sums and vertex count.
// ----------------------------------------------------------------------------
`default_nettype none

module pnn_front import pnn_pkg::*; #(
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int unsigned CNT_W       = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vtx_valid_i,
  output logic                         vtx_ready_o,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] vz_i,
  input  logic                         last_i,
  output logic                         push_o,
  input  logic                         full_i,
  output job_t                         job_o,
  output logic [CNT_W-1:0]             count_o,
  output logic                         ovf_o
);

  localparam int unsigned PW = 2 * (COORD_BITS + 1);

  front_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] first_q [3];
  logic signed [COORD_BITS-1:0] prev_q  [3];
  logic signed [COORD_BITS-1:0] vin     [3];
  logic signed [COORD_BITS-1:0] eb      [3];
  logic signed [COORD_BITS:0]   dif     [3];
  logic signed [COORD_BITS:0]   sm      [3];
  logic signed [PW-1:0]         prod_d  [3];
  logic signed [PW-1:0]         prod_q  [3];
  logic                         prod_vld_d, prod_vld_q;
  logic [2:0][ACC_W-1:0]        acc_q;
  logic [2:0][SUM_W-1:0]        sum_q;
  logic [CNT_W-1:0]             count_q;
  logic                         start_q, ovf_q;
  logic                         accept;

  assign vin[0] = vx_i;
  assign vin[1] = vy_i;
  assign vin[2] = vz_i;

  assign vtx_ready_o = (state_q == F_RUN);
  assign accept      = vtx_valid_i && vtx_ready_o;
  assign push_o      = (state_q == F_PUSH) && !full_i;

  // One edge per cycle while vertices are accepted: previous vertex against the new one, or the closing edge.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eb[i] = (state_q == F_CLOSE) ? first_q[i] : vin[i];
    end
    for (int i = 0; i < 3; i++) begin
      dif[i]    = (COORD_BITS+1)'(prev_q[(i+1)%3]) - (COORD_BITS+1)'(eb[(i+1)%3]);
      sm[i]     = (COORD_BITS+1)'(prev_q[(i+2)%3]) + (COORD_BITS+1)'(eb[(i+2)%3]);
      prod_d[i] = dif[i] * sm[i];
    end
    prod_vld_d = (accept && !start_q) || (state_q == F_CLOSE);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_RUN:   if (accept && last_i) state_d = F_CLOSE;
      F_CLOSE: state_d = F_WAIT;
      F_WAIT:  state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_RUN;
      default: state_d = F_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_RUN;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
      sum_q      <= '0;
      count_q    <= '0;
      start_q    <= 1'b1;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= prod_vld_d;
      if (prod_vld_q) begin
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= acc_q[i] + ACC_W'(prod_q[i]);
        end
      end
      if (accept) begin
        start_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i] + SUM_W'(vin[i]);
        end
        if (count_q >= CNT_W'(MAX_VERTICES)) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (push_o) begin
        acc_q   <= '0;
        sum_q   <= '0;
        count_q <= '0;
        start_q <= 1'b1;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      prev_q <= vin;
      if (start_q) first_q <= vin;
    end
  end

  assign job_o.acc = acc_q;
  assign job_o.sum = sum_q;
  assign count_o   = count_q;
  assign ovf_o     = ovf_q;

endmodule

`default_nettype wire

// File: rtl/core/pnn_queue.sv
// ----------------------------------------------------------------------------
// pnn_queue
// Short register queue between the intake and the plane solver.
// ----------------------------------------------------------------------------
`default_nettype none

module pnn_queue import pnn_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   fill_q;

  assign full_o  = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      fill_q <= fill_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/core/pnn_div.sv
// ----------------------------------------------------------------------------
// pnn_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pnn_div import pnn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dvd_i,
  input  logic [DIV_W-1:0] dvs_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dvd_q, rem_q, dvs_q;
  logic [DIV_W:0]   sh;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             take;

  assign sh   = {rem_q, dvd_q[DIV_W-1]};
  assign take = (sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DIV_W'(sh - {1'b0, dvs_q}) : sh[DIV_W-1:0];
      dvd_q <= {dvd_q[DIV_W-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

`default_nettype wire

// File: rtl/core/pnn_back.sv
// ----------------------------------------------------------------------------
// pnn_back
// Plane solver: normalisation, square root, divisions and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_plane_newell_defines.svh"

module pnn_back import pnn_pkg::*; #(
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  parameter int unsigned CNT_W            = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [TOL_W-1:0]   tol_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  job_t               job_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               ovf_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  localparam int unsigned NW = NORMAL_FRAC_BITS + 2;
  localparam logic [DIV_W-1:0] POS_MAX = DIV_W'((64'd1 << (OFFSET_W - 1)) - 64'd1);
  localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'(64'd1 << (OFFSET_W - 1));

  back_state_e state_q, state_d;

  logic [ACC_W-1:0]     mag_q [3];
  logic                 sgn_q [3];
  logic [SUM_W-1:0]     sum_q [3];
  logic signed [NW-1:0] nrm_q [3];
  logic [CNT_W-1:0]     cnt_q;
  logic                 ovf_q, deg_q;
  logic [1:0]           idx_q;
  logic [DIV_W-1:0]     ss_q, x_q, res_q, bit_q, dot_q;
  logic [OFFSET_W-1:0]  off_q;
  logic                 out_vld_q;
  result_t              out_q;

  logic                 deg, shr, shl;
  logic [61:0]          sq;
  logic [DIV_W-1:0]     sq_t;
  logic signed [NW+SUM_W-1:0] dprod;
  logic [DIV_W-1:0]     dmag, dvs_d, dvd_n, dvd_d, quo;
  logic                 div_start, div_busy, div_done;
  logic                 out_load;

  pnn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  ((state_q == B_DIVD_S) ? dvd_d : dvd_n),
    .dvs_i  ((state_q == B_DIVD_S) ? dvs_d : res_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    deg = 1'b1;
    shr = 1'b0;
    shl = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (mag_q[i] > ACC_W'(tol_i)) deg = 1'b0;
      if (|mag_q[i][ACC_W-1:31]) shr = 1'b1;
      if (|mag_q[i][ACC_W-1:30]) shl = 1'b0;
    end
    sq     = mag_q[idx_q][30:0] * mag_q[idx_q][30:0];
    sq_t   = res_q + bit_q;
    dvd_n  = (DIV_W'(mag_q[idx_q][30:0]) << NORMAL_FRAC_BITS) + (res_q >> 1);
    dprod  = nrm_q[idx_q] * signed'(sum_q[idx_q]);
    dmag   = dot_q[DIV_W-1] ? DIV_W'(-dot_q) : dot_q;
    dvs_d  = DIV_W'(cnt_q) << NORMAL_FRAC_BITS;
    dvd_d  = dmag + (dvs_d >> 1);
    out_load = !out_vld_q || res_ready_i;
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_MAG;
        end
      end
      B_MAG:    state_d = deg ? B_OUT : B_NORM;
      B_NORM:   if (!shr && !shl) state_d = B_SQ;
      B_SQ:     if (idx_q == 2'd2) state_d = B_SQRT;
      B_SQRT:   if (bit_q[0]) state_d = B_DIVN_S;
      B_DIVN_S: begin
        div_start = 1'b1;
        state_d   = B_DIVN_W;
      end
      B_DIVN_W: if (div_done) state_d = (idx_q == 2'd2) ? B_DOT : B_DIVN_S;
      B_DOT:    if (idx_q == 2'd2) state_d = B_DIVD_S;
      B_DIVD_S: begin
        div_start = 1'b1;
        state_d   = B_DIVD_W;
      end
      B_DIVD_W: if (div_done) state_d = B_OUT;
      B_OUT:    if (out_load) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        B_SQ, B_DOT: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        B_DIVN_W:    if (div_done) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        default:     idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          sgn_q[i] <= job_i.acc[i][ACC_W-1];
          mag_q[i] <= job_i.acc[i][ACC_W-1] ? ACC_W'(-job_i.acc[i]) : job_i.acc[i];
          sum_q[i] <= job_i.sum[i];
        end
        cnt_q <= count_i;
        ovf_q <= ovf_i;
        ss_q  <= '0;
        dot_q <= '0;
      end
      B_MAG: begin
        deg_q <= deg;
        off_q <= '0;
        nrm_q[0] <= '0;
        nrm_q[1] <= '0;
        nrm_q[2] <= NW'(1) << NORMAL_FRAC_BITS;
      end
      B_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (shr)      mag_q[i] <= mag_q[i] >> 1;
          else if (shl) mag_q[i] <= mag_q[i] << 1;
        end
        x_q   <= '0;
        res_q <= '0;
        bit_q <= DIV_W'(1) << 62;
      end
      B_SQ: begin
        ss_q <= ss_q + DIV_W'(sq);
        x_q  <= ss_q + DIV_W'(sq);
      end
      B_SQRT: begin
        if (x_q >= sq_t) begin
          x_q   <= x_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      B_DIVN_W: begin
        if (div_done) begin
          nrm_q[idx_q] <= sgn_q[idx_q] ? NW'(-quo) : NW'(quo);
        end
      end
      B_DOT: dot_q <= dot_q + DIV_W'(dprod);
      B_DIVD_W: begin
        if (div_done) begin
          if (dot_q[DIV_W-1]) begin
            off_q <= (quo > POS_MAX) ? OFFSET_W'(POS_MAX) : OFFSET_W'(quo);
          end else begin
            off_q <= (quo > NEG_MAX) ? OFFSET_W'(-NEG_MAX) : OFFSET_W'(-quo);
          end
        end
      end
      B_OUT: begin
        if (out_load) begin
          out_q.normal_x     <= NORMAL_W'(nrm_q[0]);
          out_q.normal_y     <= NORMAL_W'(nrm_q[1]);
          out_q.normal_z     <= NORMAL_W'(nrm_q[2]);
          out_q.plane_offset <= off_q;
          out_q.sum_x        <= sum_q[0];
          out_q.sum_y        <= sum_q[1];
          out_q.sum_z        <= sum_q[2];
          out_q.vertex_count <= COUNT_W'(cnt_q);
          out_q.degenerate   <= deg_q;
          out_q.overflow     <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  `PNN_ASSERT(a_deg_plane, !(out_vld_q && out_q.degenerate) || (out_q.normal_x == '0 && out_q.normal_y == '0 && out_q.plane_offset == '0), "degenerate result with a non-default plane")
  `PNN_ASSERT(a_div_idle, !div_start || !div_busy, "divider started while busy")
  `PNN_ASSERT(a_norm_range, state_q != B_SQ || ((mag_q[0][30] || mag_q[1][30] || mag_q[2][30]) && !(|mag_q[0][ACC_W-1:31]) && !(|mag_q[1][ACC_W-1:31]) && !(|mag_q[2][ACC_W-1:31])), "normal not scaled into range")
  `PNN_ASSERT_NEXT(a_pop_mag, pop_o, state_q == B_MAG, "job pop not followed by magnitude step")

endmodule

`default_nettype wire

// File: rtl/core/polygon_plane_newell.sv
// ----------------------------------------------------------------------------
// polygon_plane_newell
// Plane of a closed polygon by Newell's method, with unit normal and offset.
// ----------------------------------------------------------------------------
// Usage. Vertices arrive as requests on the s_axis channel, one per cycle while
// s_axis_tready is high, in loop order; tlast marks the final vertex. The
// intake accumulates the Newell cross terms, coordinate sums and a count, then
// takes the closing edge, waits for its product and hands the loop over.
// Each finished loop goes into a two-entry queue; the solver then normalises
// the normal by shifts, squares and takes the integer square root and runs
// four divisions on the shared bit-serial divider. A degenerate loop skips
// from the magnitude step straight to the output step. One result request
// per loop leaves on m_axis from an output register.
// If the receiver stalls, the result waits there, the solver holds its next
// result and the queue fills; then s_axis_tready stays low at a loop end.
// The cfg channel writes the null tolerance (reset value 1) and is always
// ready; write it only while the block is idle. Reset clears all loop state.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_plane_newell import pnn_pkg::*; #(
  parameter int unsigned MAX_VERTICES     = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  localparam int unsigned IN_W            = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W           = (($bits(result_t) - 2 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // vertex_x, vertex_y, vertex_z, then zero padding
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // normal_x, normal_y, normal_z, plane_offset, sum_x, sum_y, sum_z,
  // vertex_count, then zero padding
  output logic [OUT_W-1:0] m_axis_tdata,
  // degenerate, overflow
  output logic [1:0]       m_axis_tuser,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TOL_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned Q_W   = $bits(job_t) + CNT_W + 1;

  logic [TOL_W-1:0] tol_q;
  logic             push, full, pop, empty;
  job_t             job_in, job_out;
  logic [CNT_W-1:0] cnt_in, cnt_out;
  logic             ovf_in, ovf_out;
  result_t          res;

  // The tolerance register is the only configuration state.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  pnn_front #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_valid_i(s_axis_tvalid),
    .vtx_ready_o(s_axis_tready),
    .vx_i       (s_axis_tdata[COORD_BITS-1:0]),
    .vy_i       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .vz_i       (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .last_i     (s_axis_tlast),
    .push_o     (push),
    .full_i     (full),
    .job_o      (job_in),
    .count_o    (cnt_in),
    .ovf_o      (ovf_in)
  );

  pnn_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({ovf_in, cnt_in, job_in}),
    .full_o (full),
    .pop_i  (pop),
    .data_o ({ovf_out, cnt_out, job_out}),
    .empty_o(empty)
  );

  pnn_back #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
    .CNT_W           (CNT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tol_i      (tol_q),
    .empty_i    (empty),
    .pop_o      (pop),
    .job_i      (job_out),
    .count_i    (cnt_out),
    .ovf_i      (ovf_out),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  // The packed result keeps the two flags in its top bits.
  assign m_axis_tdata = OUT_W'(res[$bits(result_t)-3:0]);
  assign m_axis_tuser = {res.overflow, res.degenerate};

endmodule

`default_nettype wire
